// ----- design/c2cb_pkg.sv -----
// Package for the clamped-border 2D convolution block.
// Holds payload structs, register indexes and the FSM state type; no dependencies.
package c2cb_pkg;

   typedef struct packed {
      logic       cmd;
      logic [7:0] in_ch0;
      logic [7:0] in_ch1;
      logic [7:0] in_ch2;
      logic [7:0] in_ch3;
   } req_type;

   typedef struct packed {
      logic [7:0] out_ch0;
      logic [7:0] out_ch1;
      logic [7:0] out_ch2;
      logic [7:0] out_ch3;
      logic       out_last;
   } rsp_type;

   localparam logic [2:0] REG_COEFS0  = 3'd0;
   localparam logic [2:0] REG_COEFS1  = 3'd1;
   localparam logic [2:0] REG_COEFS2  = 3'd2;
   localparam logic [2:0] REG_COEFS3  = 3'd3;
   localparam logic [2:0] REG_RADIUS  = 3'd4;
   localparam logic [2:0] REG_DIVISOR = 3'd5;
   localparam logic [2:0] REG_WIDTH   = 3'd6;
   localparam logic [2:0] REG_HEIGHT  = 3'd7;

   localparam int CMD_DRAIN = 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_ACC,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

// ----- design/c2cb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module c2cb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- design/conv2d_clamped_border.sv -----
// Streaming 2D convolution, replicated border, up to four 8-bit lanes.
// An item that emits passes through (2R+1)^2 line-store reads, accumulation, 24 divide
// steps and an output step before its result shows. Throughput: one item per cycle when
// it emits nothing; an emitting item holds off the next until its reads, division and
// output step are done. A waiting result stalls only the output step. Synchronous reset
// clears counters and sequencer and loads configuration defaults, not the line store.
module conv2d_clamped_border
   import c2cb_pkg::*;
#(
   parameter int LINE_LEN   = 2048,
   parameter int MAX_RADIUS = 2,
   parameter int LANES      = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int LINES = 3 * MAX_RADIUS + 1;
   localparam int DEPTH = LINES * LINE_LEN;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(LINE_LEN);
   localparam int LW    = $clog2(LINES);
   localparam int KMAX  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int KW    = $clog2(KMAX + 1);
   localparam int DW    = 24;

   // Configuration registers.
   logic [63:0] coefs0_ff, coefs1_ff, coefs2_ff;
   logic [7:0]  coefs3_ff;
   logic [1:0]  radius_ff;
   logic [15:0] divisor_ff;
   logic [11:0] width_ff;
   logic [12:0] height_ff;

   // Frame counters.
   logic [CW-1:0] icol_ff, icol_in, ocol_ff, ocol_in;
   logic [12:0]   irow_ff, irow_in, orow_ff, orow_in;
   logic [LW-1:0] iline_ff, iline_in;
   logic [LW-1:0] oline_ff, oline_in;

   state_type     state_ff, state_in;
   logic [KW-1:0] kidx_ff, kidx_in;
   logic [2:0]    kx_ff, kx_in, ky_ff, ky_in;
   logic          rvalid_ff, rvalid_in;
   logic [KW-1:0] ridx_ff, ridx_in;
   logic signed [20:0] acc_ff [4];
   logic signed [20:0] acc_in [4];
   logic [4:0]    dstep_ff, dstep_in;
   logic [DW-1:0] quo_ff [4];
   logic [DW-1:0] quo_in [4];
   logic [16:0]   rem_ff [4];
   logic [16:0]   rem_in [4];
   logic [3:0]    neg_ff, neg_in;
   logic          last_ff, last_in;
   logic          rspv_ff, rspv_in;
   rsp_type       rsp_ff, rsp_in;

   // Effective geometry.
   logic [12:0] eff_w;
   logic [12:0] eff_h;
   logic [2:0]  eff_r;
   logic [15:0] eff_div;
   always_comb begin
      eff_w = (width_ff == 12'd0) ? 13'd1 : {1'b0, width_ff};
      if (32'(eff_w) > LINE_LEN) eff_w = 13'(LINE_LEN);
      eff_h = (height_ff == 13'd0) ? 13'd1 : height_ff;
      eff_r = ({1'b0, radius_ff} > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : {1'b0, radius_ff};
      eff_div = (divisor_ff == 16'd0) ? 16'd1 : divisor_ff;
   end

   // Lag test on linear pixel positions: n >= r*w + r + m.
   logic        received;
   logic [25:0] n_pos, m_pos, lag;
   always_comb begin
      received = irow_ff >= eff_h;
      n_pos = 26'(irow_ff) * 26'(eff_w) + 26'(icol_ff);
      m_pos = 26'(orow_ff) * 26'(eff_w) + 26'(ocol_ff);
      lag   = 26'(eff_r) * 26'(eff_w) + 26'(eff_r);
   end

   // A drain only emits once the whole frame is in.
   logic accept, is_pixel, do_emit, out_go;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_pixel  = (req_data.cmd != 1'(CMD_DRAIN)) && !received;
   assign do_emit   = accept && (received || (is_pixel && (n_pos >= lag + m_pos)));
   assign out_go    = !rspv_ff || rsp_ready;

   // Window address for tap (ky, kx) with border clamping.
   logic signed [14:0] rr, cc;
   logic signed [14:0] rdelta;
   logic signed [4:0]  lsum;
   logic [LW-1:0] rline;
   logic [AW-1:0] rd_addr;
   always_comb begin
      rr = $signed({2'b0, orow_ff}) + $signed({12'b0, ky_ff}) - $signed({12'b0, eff_r});
      cc = $signed(15'(ocol_ff)) + $signed({12'b0, kx_ff}) - $signed({12'b0, eff_r});
      if (rr < 0) rr = 15'sd0;
      if (rr > $signed({2'b0, eff_h}) - 15'sd1) rr = $signed({2'b0, eff_h}) - 15'sd1;
      if (cc < 0) cc = 15'sd0;
      if (cc > $signed({2'b0, eff_w}) - 15'sd1) cc = $signed({2'b0, eff_w}) - 15'sd1;
      // The clamped row sits within the radius of the output row, so its line
      // follows from the output line with at most one wrap.
      rdelta = rr - $signed(15'(orow_ff));
      lsum   = $signed(5'(oline_ff)) + $signed(rdelta[4:0]);
      if (lsum < 0) lsum = lsum + $signed(5'(LINES));
      else if (lsum >= $signed(5'(LINES))) lsum = lsum - $signed(5'(LINES));
      rline   = lsum[LW-1:0];
      rd_addr = AW'(rline) * AW'(LINE_LEN) + AW'(cc[CW-1:0]);
   end

   // Line store.
   logic [31:0] wr_px, rd_px;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   always_comb begin
      wr_px = '0;
      if (LANES > 0) wr_px[7:0]   = req_data.in_ch0;
      if (LANES > 1) wr_px[15:8]  = req_data.in_ch1;
      if (LANES > 2) wr_px[23:16] = req_data.in_ch2;
      if (LANES > 3) wr_px[31:24] = req_data.in_ch3;
      wr_en   = accept && is_pixel;
      wr_addr = AW'(iline_ff) * AW'(LINE_LEN) + AW'(icol_ff);
   end

   c2cb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_px),
      .rd_addr (rd_addr),
      .rd_data (rd_px)
   );

   // Coefficient for the tap whose data arrives now.
   logic [199:0] coef_all;
   logic signed [7:0] coef_cur;
   assign coef_all = {coefs3_ff, coefs2_ff, coefs1_ff, coefs0_ff};
   assign coef_cur = $signed(coef_all[8*ridx_ff +: 8]);

   // Next-state logic.
   logic [KW-1:0] ktot;
   assign ktot = KW'((2 * eff_r + 1) * (2 * eff_r + 1));
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (do_emit) state_in = ST_READ;
         ST_READ: if (kidx_ff == ktot - KW'(1)) state_in = ST_ACC;
         ST_ACC:  if (!rvalid_ff) state_in = ST_DIV;
         ST_DIV:  if (dstep_ff == 5'(DW - 1)) state_in = ST_OUT;
         ST_OUT:  if (out_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and counter updates.
   logic [16:0] trial;
   logic [7:0]  lane_v;
   logic [13:0] ocol_n;
   logic [13:0] orow_n;
   logic [13:0] icol_n;
   logic [7:0]  sat [4];
   always_comb begin
      icol_in = icol_ff; irow_in = irow_ff; iline_in = iline_ff;
      ocol_in = ocol_ff; orow_in = orow_ff; oline_in = oline_ff;
      kidx_in = kidx_ff; kx_in = kx_ff; ky_in = ky_ff;
      rvalid_in = 1'b0; ridx_in = kidx_ff;
      acc_in = acc_ff; quo_in = quo_ff; rem_in = rem_ff; neg_in = neg_ff;
      dstep_in = dstep_ff; last_in = last_ff;
      rspv_in = rspv_ff; rsp_in = rsp_ff;
      trial = '0; lane_v = '0;
      ocol_n = '0; orow_n = '0; icol_n = '0;
      for (int l = 0; l < 4; l++) sat[l] = '0;

      if (rspv_ff && rsp_ready) rspv_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_pixel) begin
               icol_n = 14'(icol_ff) + 14'd1;
               if (icol_n >= 14'(eff_w)) begin
                  icol_in = '0;
                  irow_in = irow_ff + 13'd1;
                  iline_in = (iline_ff == LW'(LINES - 1)) ? '0 : iline_ff + LW'(1);
               end else begin
                  icol_in = icol_n[CW-1:0];
               end
            end
            kidx_in = '0; kx_in = '0; ky_in = '0;
            for (int l = 0; l < 4; l++) acc_in[l] = '0;
         end
         ST_READ: begin
            rvalid_in = 1'b1;
            kidx_in = kidx_ff + KW'(1);
            if (kx_ff == 3'(2 * eff_r)) begin
               kx_in = '0; ky_in = ky_ff + 3'd1;
            end else begin
               kx_in = kx_ff + 3'd1;
            end
         end
         ST_ACC: begin
            dstep_in = '0;
            for (int l = 0; l < 4; l++) begin
               neg_in[l] = acc_ff[l] < 0;
               quo_in[l] = DW'(acc_ff[l] < 0 ? -acc_ff[l] : acc_ff[l]);
               rem_in[l] = '0;
            end
         end
         ST_DIV: begin
            // One restoring-division bit per cycle on each lane.
            for (int l = 0; l < 4; l++) begin
               trial = {rem_ff[l][15:0], quo_ff[l][DW-1]};
               if (trial >= {1'b0, eff_div}) begin
                  rem_in[l] = trial - {1'b0, eff_div};
                  quo_in[l] = {quo_ff[l][DW-2:0], 1'b1};
               end else begin
                  rem_in[l] = trial;
                  quo_in[l] = {quo_ff[l][DW-2:0], 1'b0};
               end
            end
            dstep_in = dstep_ff + 5'd1;
         end
         ST_OUT: begin
            // Hold here while the previous result still waits.
            if (out_go) begin
               for (int l = 0; l < 4; l++) begin
                  if (l >= LANES || neg_ff[l]) sat[l] = 8'd0;
                  else if (quo_ff[l] > DW'(255)) sat[l] = 8'd255;
                  else sat[l] = quo_ff[l][7:0];
               end
               ocol_n = 14'(ocol_ff) + 14'd1;
               orow_n = 14'(orow_ff);
               if (ocol_n >= 14'(eff_w)) begin
                  ocol_n = '0; orow_n = orow_n + 14'd1;
                  oline_in = (oline_ff == LW'(LINES - 1)) ? '0 : oline_ff + LW'(1);
               end
               last_in = orow_n >= 14'(eff_h);
               if (last_in) begin
                  icol_in = '0; irow_in = '0; iline_in = '0; ocol_in = '0; orow_in = '0;
                  oline_in = '0;
               end else begin
                  ocol_in = ocol_n[CW-1:0]; orow_in = orow_n[12:0];
               end
               rsp_in.out_ch0 = sat[0]; rsp_in.out_ch1 = sat[1];
               rsp_in.out_ch2 = sat[2]; rsp_in.out_ch3 = sat[3];
               rsp_in.out_last = last_in;
               rspv_in = 1'b1;
            end
         end
         default: ;
      endcase

      // Multiply-accumulate of the tap read in the previous cycle.
      if (rvalid_ff) begin
         for (int l = 0; l < 4; l++) begin
            lane_v = rd_px[8*l +: 8];
            acc_in[l] = acc_ff[l] + 21'($signed({1'b0, lane_v}) * coef_cur);
         end
      end

      // Geometry writes restart the frame.
      if (csr_write && (csr_index == REG_RADIUS || csr_index == REG_WIDTH ||
                        csr_index == REG_HEIGHT)) begin
         icol_in = '0; irow_in = '0; iline_in = '0; ocol_in = '0; orow_in = '0;
         oline_in = '0;
      end
   end

   // Registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rspv_ff <= 1'b0; rvalid_ff <= 1'b0;
         icol_ff <= '0; irow_ff <= '0; iline_ff <= '0; ocol_ff <= '0; orow_ff <= '0;
         oline_ff <= '0;
         coefs0_ff <= 64'd1; coefs1_ff <= '0; coefs2_ff <= '0; coefs3_ff <= '0;
         radius_ff <= '0; divisor_ff <= 16'd1; width_ff <= 12'd2048;
         height_ff <= 13'd1024;
      end else begin
         state_ff <= state_in; rspv_ff <= rspv_in; rvalid_ff <= rvalid_in;
         icol_ff <= icol_in; irow_ff <= irow_in; iline_ff <= iline_in;
         ocol_ff <= ocol_in; orow_ff <= orow_in; oline_ff <= oline_in;
         if (csr_write) begin
            unique case (csr_index)
               REG_COEFS0:  coefs0_ff  <= csr_data;
               REG_COEFS1:  coefs1_ff  <= csr_data;
               REG_COEFS2:  coefs2_ff  <= csr_data;
               REG_COEFS3:  coefs3_ff  <= csr_data[7:0];
               REG_RADIUS:  radius_ff  <= csr_data[1:0];
               REG_DIVISOR: divisor_ff <= csr_data[15:0];
               REG_WIDTH:   width_ff   <= csr_data[11:0];
               REG_HEIGHT:  height_ff  <= csr_data[12:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kidx_ff <= kidx_in; kx_ff <= kx_in; ky_ff <= ky_in; ridx_ff <= ridx_in;
      acc_ff <= acc_in; quo_ff <= quo_in; rem_ff <= rem_in; neg_ff <= neg_in;
      dstep_ff <= dstep_in; last_ff <= last_in; rsp_ff <= rsp_in;
   end

   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/c2cb_checker.sv -----
// Port-level checker for the convolution block, bound to the top level.
// Depends on c2cb_pkg.
module c2cb_checker
   import c2cb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A waiting result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // A shown result carries fully known data.
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_data))
      else $error("result data unknown");

   // Nothing is shown right after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind conv2d_clamped_border c2cb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- verif/tb_conv2d_clamped_border.sv -----
// Testbench for conv2d_clamped_border: directed table, a one-row frame, then randomized frames.
// Depends on c2cb_pkg for payload structs, register indexes and the drain code.
`timescale 1ns / 1ps

module tb_conv2d_clamped_border;
   import c2cb_pkg::*;

   localparam int LINE_W   = 2048;
   localparam int LINE_CNT = 7;
   localparam int SETTLE   = 80;
   localparam int ROW_PIX  = 40;

   typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type    item;
      bit         typed;
      bit         want_none;
      rsp_type    want;
      logic [2:0] index;
      logic [63:0] data;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   // Predictor copy of the configuration and the frame state.
   logic [63:0] cf0, cf1, cf2;
   logic [7:0]  cf3;
   logic [1:0]  radius_reg;
   logic [15:0] divisor_reg;
   logic [11:0] width_reg;
   logic [12:0] height_reg;
   logic [31:0] pixel_lines [LINE_CNT*LINE_W];
   int          in_col, in_row, out_col, out_row;

   rsp_type      pending_pixels[$];
   stim_row_type directed[$];
   int          errors = 0;
   int          send_idle = 0;
   int          stall_pct = 0;
   bit          hold_go = 0;
   bit          hold_on = 0;
   int          sent = 0;

   conv2d_clamped_border dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #30ms;
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int eff_w();
      int w;
      w = (width_reg == 0) ? 1 : int'(width_reg);
      return (w > LINE_W) ? LINE_W : w;
   endfunction

   function automatic int eff_h();
      return (height_reg == 0) ? 1 : int'(height_reg);
   endfunction

   function automatic int eff_r();
      return (radius_reg > 2) ? 2 : int'(radius_reg);
   endfunction

   function automatic int coef_at(int k);
      logic [63:0] wd;
      logic [7:0]  b;
      wd = (k < 8) ? cf0 : (k < 16) ? cf1 : (k < 24) ? cf2 : {56'd0, cf3};
      b = wd[(k % 8) * 8 +: 8];
      return int'($signed(b));
   endfunction

   function automatic void clear_frame();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
   endfunction

   // Filter the pixel at the output position and advance it.
   function automatic rsp_type filter_pixel();
      int w, h, r, dv, sum, q, rr, cc, k;
      logic [31:0] px;
      logic [7:0]  lane_out [4];
      rsp_type     o;
      w = eff_w(); h = eff_h(); r = eff_r();
      dv = (divisor_reg == 0) ? 1 : int'(divisor_reg);
      for (int lane = 0; lane < 4; lane++) begin
         sum = 0;
         for (int dy = -r; dy <= r; dy++) begin
            for (int dx = -r; dx <= r; dx++) begin
               rr = out_row + dy;
               cc = out_col + dx;
               k = (dy + r) * (2 * r + 1) + (dx + r);
               if (rr < 0) rr = 0;
               if (rr > h - 1) rr = h - 1;
               if (cc < 0) cc = 0;
               if (cc > w - 1) cc = w - 1;
               px = pixel_lines[(rr % LINE_CNT) * LINE_W + cc];
               sum += int'(px[lane*8 +: 8]) * coef_at(k);
            end
         end
         q = sum / dv;
         if (q < 0) q = 0;
         if (q > 255) q = 255;
         lane_out[lane] = q[7:0];
      end
      o.out_ch0 = lane_out[0];
      o.out_ch1 = lane_out[1];
      o.out_ch2 = lane_out[2];
      o.out_ch3 = lane_out[3];
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      o.out_last = (out_row >= h);
      if (o.out_last) clear_frame();
      return o;
   endfunction

   // Returns 1 when the item produces a filtered pixel.
   function automatic bit conv_predict(req_type it, output rsp_type o);
      int w, h, r;
      longint lag, n, m;
      bit done;
      w = eff_w(); h = eff_h(); r = eff_r();
      lag = longint'(r) * w + r;
      done = (in_row >= h);
      o = '0;
      if (it.cmd != CMD_DRAIN && !done) begin
         n = longint'(in_row) * w + in_col;
         m = longint'(out_row) * w + out_col;
         pixel_lines[(in_row % LINE_CNT) * LINE_W + in_col] =
            {it.in_ch3, it.in_ch2, it.in_ch1, it.in_ch0};
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         if (n >= lag + m) begin
            o = filter_pixel();
            return 1;
         end
         return 0;
      end
      if (done) begin
         o = filter_pixel();
         return 1;
      end
      return 0;
   endfunction

   function automatic void apply_reg(logic [2:0] idx, logic [63:0] d);
      case (idx)
         REG_COEFS0:  cf0 = d;
         REG_COEFS1:  cf1 = d;
         REG_COEFS2:  cf2 = d;
         REG_COEFS3:  cf3 = d[7:0];
         REG_RADIUS:  begin radius_reg = d[1:0]; clear_frame(); end
         REG_DIVISOR: divisor_reg = d[15:0];
         REG_WIDTH:   begin width_reg = d[11:0]; clear_frame(); end
         REG_HEIGHT:  begin height_reg = d[12:0]; clear_frame(); end
         default: ;
      endcase
   endfunction

   // Let every expected pixel arrive and the block settle before a write.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [63:0] d);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      apply_reg(idx, d);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one item, wait for acceptance, then record what it should produce.
   task automatic send_item(req_type it, bit typed, bit want_none, rsp_type want);
      rsp_type got;
      bit      has;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      has = conv_predict(it, got);
      if (typed) begin
         if (!want_none) pending_pixels.push_back(want);
      end else if (has) begin
         pending_pixels.push_back(got);
      end
      sent++;
   endtask

   function automatic req_type rand_pixel();
      req_type it;
      it.cmd    = 1'b0;
      it.in_ch0 = $urandom;
      it.in_ch1 = $urandom;
      it.in_ch2 = $urandom;
      it.in_ch3 = $urandom;
      return it;
   endfunction

   function automatic req_type drain_item();
      req_type it;
      it = rand_pixel();
      it.cmd = 1'b1;
      return it;
   endfunction

   function automatic logic [63:0] rand_coefs();
      logic [63:0] wd;
      int b;
      for (int i = 0; i < 8; i++) begin
         b = ($urandom_range(3) == 0) ? int'($urandom_range(255)) : $urandom_range(0, 5) - 2;
         wd[i*8 +: 8] = b[7:0];
      end
      return wd;
   endfunction

   function automatic void add_item(req_type it, bit typed, bit want_none, rsp_type want);
      stim_row_type row;
      row = '{kind: ROW_ITEM, item: it, typed: typed, want_none: want_none, want: want,
              index: '0, data: '0};
      directed.push_back(row);
   endfunction

   function automatic void add_cfg(logic [2:0] idx, logic [63:0] d);
      stim_row_type row;
      row = '{kind: ROW_CFG, item: '0, typed: 0, want_none: 0, want: '0,
              index: idx, data: d};
      directed.push_back(row);
   endfunction

   function automatic req_type pix(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
      req_type it;
      it = '{cmd: 1'b0, in_ch0: a, in_ch1: b, in_ch2: c, in_ch3: d};
      return it;
   endfunction

   function automatic rsp_type same(req_type it);
      rsp_type o;
      o = '{out_ch0: it.in_ch0, out_ch1: it.in_ch1, out_ch2: it.in_ch2,
            out_ch3: it.in_ch3, out_last: 1'b0};
      return o;
   endfunction

   function automatic void build_directed();
      req_type p;
      // Reset settings: identity kernel, no lag, so each pixel comes straight back.
      p = pix(8'h00, 8'h00, 8'h00, 8'h00); add_item(p, 1, 0, same(p));
      p = pix(8'hff, 8'hff, 8'hff, 8'hff); add_item(p, 1, 0, same(p));
      p = pix(8'h01, 8'h02, 8'h04, 8'h08); add_item(p, 1, 0, same(p));
      p = pix(8'h80, 8'h40, 8'h20, 8'h10); add_item(p, 1, 0, same(p));
      // A drain while the frame is still arriving is dropped.
      p = pix(8'h00, 8'h00, 8'h00, 8'h00); p.cmd = 1'b1; add_item(p, 1, 1, '0);
      p = pix(8'hff, 8'hff, 8'hff, 8'hff); p.cmd = 1'b1; add_item(p, 1, 1, '0);
      p = pix(8'haa, 8'h55, 8'hf0, 8'h0f); add_item(p, 1, 0, same(p));
      p = pix(8'h7f, 8'h80, 8'hfe, 8'h01); add_item(p, 1, 0, same(p));
      // 3x2 frame, 3x3 box filter.
      add_cfg(REG_WIDTH, 64'd3);
      add_cfg(REG_HEIGHT, 64'd2);
      add_cfg(REG_RADIUS, 64'd1);
      add_cfg(REG_COEFS0, 64'h0101_0101_0101_0101);
      add_cfg(REG_COEFS1, 64'h0000_0000_0000_0001);
      add_cfg(REG_DIVISOR, 64'd9);
      add_item(pix(8'h10, 8'hff, 8'h00, 8'h33), 0, 0, '0);
      add_item(pix(8'h20, 8'hff, 8'hff, 8'h44), 0, 0, '0);
      add_item(pix(8'h30, 8'h00, 8'h00, 8'h55), 0, 0, '0);
      add_item(pix(8'h40, 8'hff, 8'hff, 8'h66), 0, 0, '0);
      add_item(pix(8'h50, 8'h00, 8'h80, 8'h77), 0, 0, '0);
      add_item(pix(8'h60, 8'hff, 8'h01, 8'h88), 0, 0, '0);
      add_item(drain_item(), 0, 0, '0);
      // A pixel after the whole frame is in acts as a drain.
      add_item(pix(8'h99, 8'h99, 8'h99, 8'h99), 0, 0, '0);
      add_item(drain_item(), 0, 0, '0);
      add_item(drain_item(), 0, 0, '0);
      // Radius past the maximum, zero geometry, extreme coefficients, zero divisor.
      add_cfg(REG_RADIUS, 64'd3);
      add_cfg(REG_WIDTH, 64'd0);
      add_cfg(REG_HEIGHT, 64'd0);
      add_cfg(REG_COEFS0, 64'h8080_8080_8080_8080);
      add_cfg(REG_COEFS1, 64'h7f7f_7f7f_7f7f_7f7f);
      add_cfg(REG_COEFS2, 64'h807f_807f_807f_807f);
      add_cfg(REG_COEFS3, 64'h0000_0000_0000_007f);
      add_cfg(REG_DIVISOR, 64'd0);
      add_item(pix(8'hff, 8'h00, 8'h80, 8'h7f), 0, 0, '0);
      add_item(drain_item(), 0, 0, '0);
      add_cfg(REG_DIVISOR, 64'hffff);
      add_item(pix(8'hff, 8'hff, 8'hff, 8'hff), 0, 0, '0);
      add_item(drain_item(), 0, 0, '0);
   endfunction

   // Result checker.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected pixel", int'(rsp_data.out_ch0), 0);
         end else begin
            e = pending_pixels.pop_front();
            if (rsp_data.out_ch0 !== e.out_ch0)
               report_mismatch("ch0", int'(rsp_data.out_ch0), int'(e.out_ch0));
            if (rsp_data.out_ch1 !== e.out_ch1)
               report_mismatch("ch1", int'(rsp_data.out_ch1), int'(e.out_ch1));
            if (rsp_data.out_ch2 !== e.out_ch2)
               report_mismatch("ch2", int'(rsp_data.out_ch2), int'(e.out_ch2));
            if (rsp_data.out_ch3 !== e.out_ch3)
               report_mismatch("ch3", int'(rsp_data.out_ch3), int'(e.out_ch3));
            if (rsp_data.out_last !== e.out_last)
               report_mismatch("last", int'(rsp_data.out_last), int'(e.out_last));
         end
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      if (hold_on) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // One long receiver hold, counted here while the sender keeps offering items.
   initial begin
      wait (hold_go);
      hold_on = 1'b1;
      repeat (400) @(posedge clock);
      hold_on = 1'b0;
   end

   initial begin
      int idle_set [4][2] = '{'{0, 0}, '{76, 0}, '{0, 76}, '{14, 14}};
      int phase, npix, frames;
      logic [63:0] dv;
      cf0 = 64'd1; cf1 = '0; cf2 = '0; cf3 = '0;
      radius_reg = '0; divisor_reg = 16'd1; width_reg = 12'd2048; height_reg = 13'd1024;
      clear_frame();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table.
      build_directed();
      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CFG) begin
            wait_idle();
            write_reg(directed[i].index, directed[i].data);
         end else begin
            send_item(directed[i].item, directed[i].typed, directed[i].want_none,
                      directed[i].want);
         end
      end

      // One-row frame with the widest kernel, so every pixel comes out from drain items.
      wait_idle();
      write_reg(REG_WIDTH, 64'(ROW_PIX));
      write_reg(REG_HEIGHT, 64'd1);
      write_reg(REG_RADIUS, 64'd2);
      write_reg(REG_COEFS0, rand_coefs());
      write_reg(REG_DIVISOR, 64'd3);
      for (int i = 0; i < ROW_PIX; i++) send_item(rand_pixel(), 0, 0, '0);
      while (in_row >= eff_h()) send_item(drain_item(), 0, 0, '0);

      // Random frames over several settings and idling patterns.
      phase = 0;
      while (sent < 600) begin
         wait_idle();
         send_idle = idle_set[phase % 4][0];
         stall_pct = idle_set[phase % 4][1];
         write_reg(REG_COEFS0, rand_coefs());
         write_reg(REG_COEFS1, rand_coefs());
         write_reg(REG_COEFS2, rand_coefs());
         write_reg(REG_COEFS3, {$urandom, $urandom});
         write_reg(REG_RADIUS, 64'($urandom_range(3)));
         case ($urandom_range(4))
            0: dv = 64'd0;
            1: dv = 64'($urandom_range(1, 16));
            2: dv = 64'($urandom_range(1, 300));
            3: dv = 64'hffff;
            default: dv = {$urandom, $urandom};
         endcase
         write_reg(REG_DIVISOR, dv);
         write_reg(REG_WIDTH, ($urandom_range(9) == 0) ? 64'd0 : 64'($urandom_range(1, 8)));
         write_reg(REG_HEIGHT, ($urandom_range(9) == 0) ? 64'd0 : 64'($urandom_range(1, 5)));
         if (phase == 0) hold_go = 1;
         frames = $urandom_range(2, 5);
         for (int f = 0; f < frames; f++) begin
            npix = eff_w() * eff_h();
            // Now and then a frame is cut short; the next settings restart it.
            if ($urandom_range(19) == 0) begin
               npix = npix / 2;
               for (int i = 0; i < npix; i++) send_item(rand_pixel(), 0, 0, '0);
               break;
            end
            for (int i = 0; i < npix; i++) begin
               if ($urandom_range(29) == 0) send_item(drain_item(), 0, 0, '0);
               send_item(rand_pixel(), 0, 0, '0);
            end
            while (in_row >= eff_h()) begin
               if ($urandom_range(7) == 0) send_item(rand_pixel(), 0, 0, '0);
               else send_item(drain_item(), 0, 0, '0);
            end
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
